### design/lbcs_pkg.sv
package lbcs_pkg;

    // Width of the elapsed-time counter.
    localparam int TIME_BITS = 16;
    localparam int CFG_TIME_W = 16;
    localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int EDGE_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIT_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINKS1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLINKS2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLINKS3    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MSK = 3'd7;

    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SELECT = 1'b1;

    localparam logic [1:0] PAT_OFF = 2'd0;
    localparam logic [1:0] PAT_1   = 2'd1;
    localparam logic [1:0] PAT_2   = 2'd2;
    localparam logic [1:0] PAT_3   = 2'd3;

    localparam logic [CFG_TIME_W-1:0] RST_ON_TIME    = 16'd150;
    localparam logic [CFG_TIME_W-1:0] RST_OFF_TIME   = 16'd150;
    localparam logic [CFG_TIME_W-1:0] RST_REPEAT_GAP = 16'd3000;
    localparam logic                  RST_LIT_LEVEL  = 1'b1;
    localparam logic [3:0]            RST_BLINKS1    = 4'd3;
    localparam logic [3:0]            RST_BLINKS2    = 4'd2;
    localparam logic [3:0]            RST_BLINKS3    = 4'd5;
    localparam logic [2:0]            RST_REPEAT_MSK = 3'd3;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] on_time_ms;
        logic [CFG_TIME_W-1:0] off_time_ms;
        logic [CFG_TIME_W-1:0] repeat_gap_ms;
        logic                  lit_pin_level;
        logic [3:0]            blinks_code1;
        logic [3:0]            blinks_code2;
        logic [3:0]            blinks_code3;
        logic [2:0]            repeat_mask;
    } t_cfg;

endpackage

### design/lbcs_in_if.sv
interface lbcs_in_if;
    import lbcs_pkg::*;

    logic       valid;
    logic       ready;
    logic       action;
    logic [1:0] pattern_select;

    modport source (output valid, output action, output pattern_select, input ready);
    modport sink (input valid, input action, input pattern_select, output ready);
endinterface

### design/lbcs_out_if.sv
interface lbcs_out_if;
    import lbcs_pkg::*;

    logic       valid;
    logic       ready;
    logic       led_level;
    logic [1:0] active_pattern;

    modport source (output valid, output led_level, output active_pattern, input ready);
    modport sink (input valid, input led_level, input active_pattern, output ready);
endinterface

### design/lbcs_cfg.sv
module lbcs_cfg
    import lbcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_time_ms    <= RST_ON_TIME;
            r_cfg.off_time_ms   <= RST_OFF_TIME;
            r_cfg.repeat_gap_ms <= RST_REPEAT_GAP;
            r_cfg.lit_pin_level <= RST_LIT_LEVEL;
            r_cfg.blinks_code1  <= RST_BLINKS1;
            r_cfg.blinks_code2  <= RST_BLINKS2;
            r_cfg.blinks_code3  <= RST_BLINKS3;
            r_cfg.repeat_mask   <= RST_REPEAT_MSK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ON_TIME:    r_cfg.on_time_ms    <= i_cfg_data;
                REG_OFF_TIME:   r_cfg.off_time_ms   <= i_cfg_data;
                REG_REPEAT_GAP: r_cfg.repeat_gap_ms <= i_cfg_data;
                REG_LIT_LEVEL:  r_cfg.lit_pin_level <= i_cfg_data[0];
                REG_BLINKS1:    r_cfg.blinks_code1  <= i_cfg_data[3:0];
                REG_BLINKS2:    r_cfg.blinks_code2  <= i_cfg_data[3:0];
                REG_BLINKS3:    r_cfg.blinks_code3  <= i_cfg_data[3:0];
                REG_REPEAT_MSK: r_cfg.repeat_mask   <= i_cfg_data[2:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/lbcs_engine.sv
module lbcs_engine
    import lbcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic       i_action,
    input  logic [1:0] i_pattern_select,
    output logic       o_led_level,
    output logic [1:0] o_pattern
);

    logic [1:0]           r_pattern, n_pattern;
    logic [EDGE_W-1:0]    r_edges,   n_edges;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic                 r_phase,   n_phase;
    logic                 r_lit,     n_lit;

    logic [TIME_BITS-1:0] elapsed_inc;
    logic [3:0]           blinks;
    logic                 repeats;
    logic [EDGE_W-1:0]    target;
    logic [CMP_W-1:0]     elapsed_cmp;
    logic [CMP_W-1:0]     thr_cmp;
    logic [CMP_W-1:0]     gap_cmp;

    always_comb begin
        unique case (r_pattern)
            PAT_1: begin
                blinks  = i_cfg.blinks_code1;
                repeats = i_cfg.repeat_mask[0];
            end
            PAT_2: begin
                blinks  = i_cfg.blinks_code2;
                repeats = i_cfg.repeat_mask[1];
            end
            PAT_3: begin
                blinks  = i_cfg.blinks_code3;
                repeats = i_cfg.repeat_mask[2];
            end
            default: begin
                blinks  = 4'd0;
                repeats = 1'b0;
            end
        endcase
    end

    // The time counter saturates rather than wrapping.
    assign elapsed_inc = (r_elapsed == {TIME_BITS{1'b1}}) ? r_elapsed
                                                            : TIME_BITS'(r_elapsed + 1'b1);
    assign target      = {blinks, 1'b0};
    assign elapsed_cmp = CMP_W'(elapsed_inc);
    assign thr_cmp     = CMP_W'(r_phase ? i_cfg.on_time_ms : i_cfg.off_time_ms);
    assign gap_cmp     = CMP_W'(i_cfg.repeat_gap_ms);

    always_comb begin
        n_pattern = r_pattern;
        n_edges   = r_edges;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        n_lit     = r_lit;
        if (i_action == ACT_SELECT) begin
            // Phase and pin are kept; the pin only moves on the next tick.
            n_pattern = i_pattern_select;
            n_edges   = '0;
            n_elapsed = '0;
        end else begin
            n_elapsed = elapsed_inc;
            if (r_pattern == PAT_OFF) begin
                n_lit = 1'b0;
            end else begin
                if (r_edges == '0) begin
                    n_lit = 1'b0;
                end
                if (r_edges < target) begin
                    if (elapsed_cmp >= thr_cmp) begin
                        n_phase   = !r_phase;
                        n_lit     = !r_phase;
                        n_elapsed = '0;
                        n_edges   = EDGE_W'(r_edges + 1'b1);
                    end
                end else if (repeats) begin
                    if (elapsed_cmp >= gap_cmp) begin
                        n_edges = '0;
                        n_lit   = 1'b0;
                    end
                end else begin
                    n_lit     = 1'b0;
                    n_pattern = PAT_OFF;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PAT_OFF;
            r_edges   <= '0;
            r_elapsed <= '0;
            r_phase   <= 1'b0;
            r_lit     <= 1'b0;
        end else if (i_step) begin
            r_pattern <= n_pattern;
            r_edges   <= n_edges;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            r_lit     <= n_lit;
        end
    end

    assign o_led_level = n_lit ? i_cfg.lit_pin_level : !i_cfg.lit_pin_level;
    assign o_pattern   = n_pattern;

endmodule

### design/led_blink_code_sequencer_top.sv
// Status LED blink-code sequencer.
// Input channel i_item carries one beat per event: action 0 is a one-millisecond
// tick, action 1 selects pattern_select (0 off, 1 to 3 the numbered codes).
// Output channel o_result returns exactly one beat per input beat: the LED pin
// level after that event and the pattern now running.
// An accepted input beat is captured in an input register; when it steps, the
// sequencer state is updated and the result lands in the output register.
// Throughput is one beat per cycle unless the receiver stalls; the state
// update is a single pass of a counter step and a few compares, so
// back-to-back beats are taken.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and i_item.ready drops only once both are occupied.
// Registers are written on the i_cfg_* port (index 0 on-time, 1 off-time,
// 2 repeat gap, 3 lit pin level, 4 to 6 blink counts, 7 repeat mask); the user
// must write them only while the block is idle, which the block does not enforce.
// Synchronous reset clears the valid bits of both pipeline registers, the
// sequencer (off, dark) and restores the register defaults.
module led_blink_code_sequencer_top
    import lbcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lbcs_in_if.sink               i_item,
    lbcs_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       cfg;
    logic       r_in_valid;
    logic       r_in_action;
    logic [1:0] r_in_pattern;
    logic       r_out_valid;
    logic       r_out_led;
    logic [1:0] r_out_pattern;
    logic       out_free;
    logic       step;
    logic       in_take;
    logic       step_led;
    logic [1:0] step_pattern;

    lbcs_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lbcs_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_step           (step),
        .i_action         (r_in_action),
        .i_pattern_select (r_in_pattern),
        .o_led_level      (step_led),
        .o_pattern        (step_pattern)
    );

    assign out_free       = !r_out_valid || o_result.ready;
    assign step           = r_in_valid && out_free;
    assign i_item.ready   = !r_in_valid || out_free;
    assign in_take        = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action  <= i_item.action;
            r_in_pattern <= i_item.pattern_select;
        end
        if (step) begin
            r_out_led     <= step_led;
            r_out_pattern <= step_pattern;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.led_level      = r_out_led;
    assign o_result.active_pattern = r_out_pattern;

endmodule
